/* hdl/adcrd_pkg.sv */
`default_nettype none
package adcrd_pkg;

  localparam int unsigned HalfW     = 8;
  localparam int unsigned ChipW     = 2;
  localparam int unsigned ChanW     = 3;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned SampleW   = 8;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 16;

  localparam logic [HalfW-1:0] HalfReset  = 8'd4;
  localparam logic [SlotW-1:0] SlotMuxEnd = 4'd4;
  localparam logic [SlotW-1:0] SlotSample = 4'd6;
  localparam logic [SlotW-1:0] SlotLast   = 4'd13;

  typedef struct packed {
    logic               start_req;
    logic [ChipW-1:0]   chip;
    logic [ChanW-1:0]   channel;
    logic               miso;
  } req_t;

  typedef struct packed {
    logic               sclk;
    logic               mosi;
    logic [ChipW-1:0]   chip_select;
    logic               board_enable_n;
    logic               busy_res;
    logic               done_res;
    logic [SampleW-1:0] value;
  } res_t;

  function automatic logic [OutDataW-1:0] pack_res(input res_t r);
    return {r.value, 1'b0, r.done_res, r.busy_res, r.board_enable_n,
            r.chip_select, r.mosi, r.sclk};
  endfunction

  function automatic req_t unpack_req(input logic [InDataW-1:0] d);
    req_t r;
    r.start_req = d[0];
    r.chip      = d[2:1];
    r.channel   = d[5:3];
    r.miso      = d[6];
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/adcrd_seq.sv */
`default_nettype none
module adcrd_seq import adcrd_pkg::*; (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              step,
  input  req_t             req,
  input  wire [HalfW-1:0]  half_ticks,
  output res_t             res
);

  logic               running_r, running_nxt;
  logic [SlotW-1:0]   slot_r, slot_nxt;
  logic               high_r, high_nxt;
  logic [HalfW-1:0]   tick_r, tick_nxt;
  logic [SampleW-1:0] shift_r, shift_nxt;
  logic [3:0]         mux_r, mux_nxt;
  logic [ChipW-1:0]   chip_r, chip_nxt;
  logic               data_r, data_nxt;
  logic               enable_r, enable_nxt;
  logic               done;
  logic [HalfW-1:0]   limit;
  logic               half_end;
  logic [SlotW-1:0]   slot_inc;
  logic [1:0]         mux_idx;

  assign limit    = (half_ticks == '0) ? HalfW'(1) : half_ticks;
  assign half_end = ({1'b0, tick_r} + 9'd1) >= {1'b0, limit};
  assign slot_inc = slot_r + SlotW'(1);
  // slot n (1..4) sends mux bit 4-n
  assign mux_idx  = 2'(SlotMuxEnd - slot_inc);

  always_comb begin
    running_nxt = running_r;
    slot_nxt    = slot_r;
    high_nxt    = high_r;
    tick_nxt    = tick_r;
    shift_nxt   = shift_r;
    mux_nxt     = mux_r;
    chip_nxt    = chip_r;
    data_nxt    = data_r;
    enable_nxt  = enable_r;
    done        = 1'b0;
    if (!running_r) begin
      if (req.start_req) begin
        chip_nxt    = req.chip;
        mux_nxt     = {1'b1, req.channel[0], req.channel[2], req.channel[1]};
        running_nxt = 1'b1;
        enable_nxt  = 1'b0;
        slot_nxt    = '0;
        high_nxt    = 1'b0;
        tick_nxt    = '0;
        data_nxt    = 1'b1;
      end
    end else if (half_end) begin
      tick_nxt = '0;
      if (!high_r) begin
        high_nxt = 1'b1;
      end else begin
        if (slot_r >= SlotSample) begin
          shift_nxt = {shift_r[SampleW-2:0], req.miso};
        end
        high_nxt = 1'b0;
        if (slot_r >= SlotLast) begin
          running_nxt = 1'b0;
          slot_nxt    = '0;
          enable_nxt  = 1'b1;
          done        = 1'b1;
        end else begin
          slot_nxt = slot_inc;
          if (slot_inc <= SlotMuxEnd) begin
            data_nxt = mux_r[mux_idx];
          end
        end
      end
    end else begin
      tick_nxt = tick_r + HalfW'(1);
    end
  end

  always_comb begin
    res.sclk           = running_nxt & high_nxt;
    res.mosi           = data_nxt;
    res.chip_select    = chip_nxt;
    res.board_enable_n = enable_nxt;
    res.busy_res       = running_nxt;
    res.done_res       = done;
    res.value          = shift_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      slot_r    <= '0;
      high_r    <= 1'b0;
      tick_r    <= '0;
      shift_r   <= '0;
      mux_r     <= '0;
      chip_r    <= '0;
      data_r    <= 1'b0;
      enable_r  <= 1'b1;
    end else if (step) begin
      running_r <= running_nxt;
      slot_r    <= slot_nxt;
      high_r    <= high_nxt;
      tick_r    <= tick_nxt;
      shift_r   <= shift_nxt;
      mux_r     <= mux_nxt;
      chip_r    <= chip_nxt;
      data_r    <= data_nxt;
      enable_r  <= enable_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_enable_tracks_run: assert property (@(posedge clk) disable iff (!rst_n)
    enable_r == !running_r) else $error("enable out of step with run state");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SlotLast) else $error("bit slot past last cycle");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (slot_r == '0 && !high_r)) else $error("idle with slot state");
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done) |=> !running_r) else $error("done without end of run");
`endif

endmodule
`default_nettype wire

/* hdl/serial_adc_channel_reader.sv */
`default_nettype none
// Serial ADC channel reader: pin-level sequencer for one 8-bit conversion
// from one of four serial ADC chips.
// in_*  : one transfer per sequencer tick; tdata carries start request,
//         chip, channel and the sampled data line level.
// out_* : one transfer per accepted tick, carrying the pin levels, status
//         and sample value after that tick's update.
// cfg_* : half period of the serial clock in ticks (0 acts as 1); write only
//         while no conversion runs. cfg_ready is always high.
// The single result register between state and output holds the result in
// the cycle after the transfer; one item per cycle while out_tready is high.
// A full conversion takes 28 * half period ticks after the start tick.
// Reset: idle, enable high, half period 4, value 0.
// When out_tready is low with a result held, in_tready drops and the
// sequencer state does not advance until the result is taken.
module serial_adc_channel_reader import adcrd_pkg::*; (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  // [0] start_req, [2:1] chip, [5:3] channel, [6] miso, [7] zero
  input  wire [InDataW-1:0]   in_tdata,
  output logic                out_tvalid,
  input  wire                 out_tready,
  // [0] sclk, [1] mosi, [3:2] chip_select, [4] board_enable_n,
  // [5] busy_res, [6] done_res, [7] zero, [15:8] value
  output logic [OutDataW-1:0] out_tdata,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [HalfW-1:0]     cfg_data
);

  logic              step;
  logic [HalfW-1:0]  half_r;
  res_t              res;
  logic [OutDataW-1:0] data_r;
  logic              valid_r;

  assign in_tready  = !valid_r || out_tready;
  assign step       = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HalfReset;
    end else if (cfg_valid) begin
      half_r <= cfg_data;
    end
  end

  adcrd_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .req        (unpack_req(in_tdata)),
    .half_ticks (half_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data_r <= pack_res(res);
    end
  end

endmodule
`default_nettype wire
